/* sv/kst_pkg.sv */
// Shared types, constants and helper functions for the keypad countdown timer.
`timescale 1ns / 1ps

package kst_pkg;

  // Operating modes, encoded as they appear on the mode output.
  typedef enum logic [2:0] {
    MODE_INIT    = 3'd0,
    MODE_MAIN    = 3'd1,
    MODE_TPROMPT = 3'd2,
    MODE_TENTRY  = 3'd3,
    MODE_HPROMPT = 3'd4,
    MODE_HENTRY  = 3'd5,
    MODE_RUN     = 3'd6,
    MODE_PAUSE   = 3'd7
  } mode_t;

  // Keypad characters with a special meaning.
  localparam logic [7:0] KEY_NONE = 8'h00;
  localparam logic [7:0] KEY_ZERO = 8'h30;
  localparam logic [7:0] KEY_ONE  = 8'h31;
  localparam logic [7:0] KEY_TWO  = 8'h32;
  localparam logic [7:0] KEY_NINE = 8'h39;

  localparam logic [11:0] TPM_RESET     = 12'd300;
  localparam logic [5:0]  MINUTE_MAX    = 6'd59;
  localparam logic [3:0]  HOUR_MAX      = 4'd9;
  localparam logic [3:0]  TENS_LIMIT    = 4'd6;
  localparam logic [7:0]  SET_POINT_MAX = 8'd255;
  localparam logic [1:0]  ENTRY_DONE    = 2'd3;

  // Complete architectural state of the timer.
  typedef struct packed {
    mode_t       mode;
    logic [7:0]  held_key;
    logic [1:0]  entry_pos;
    logic [11:0] prescaler;
    logic [3:0]  hours;
    logic [5:0]  minutes;
    logic [7:0]  set_point;
    logic        run;
  } state_t;

  localparam state_t STATE_RESET = '{
    mode:      MODE_INIT,
    held_key:  8'd0,
    entry_pos: 2'd0,
    prescaler: 12'd0,
    hours:     4'd0,
    minutes:   6'd0,
    set_point: 8'd0,
    run:       1'b0
  };

  // Result of one countdown step while running.
  typedef struct packed {
    logic [11:0] prescaler;
    logic [3:0]  hours;
    logic [5:0]  minutes;
    logic        run;
    logic        refresh;
  } countdown_t;

  function automatic logic is_digit(input logic [7:0] k);
    return (k >= KEY_ZERO) && (k <= KEY_NINE);
  endfunction

  function automatic logic [3:0] digit_value(input logic [7:0] k);
    logic [7:0] diff;
    diff = k - KEY_ZERO;
    return diff[3:0];
  endfunction

  // Adds a digit at its decimal weight to the set point, saturating at the maximum.
  function automatic logic [7:0] set_point_add(input logic [7:0] sp, input logic [3:0] d,
                                               input logic [1:0] pos);
    logic [10:0] w;
    logic [10:0] s;
    case (pos)
      2'd0:    w = 11'(d) * 11'd100;
      2'd1:    w = 11'(d) * 11'd10;
      default: w = 11'(d);
    endcase
    s = 11'(sp) + w;
    return (s > 11'(SET_POINT_MAX)) ? SET_POINT_MAX : s[7:0];
  endfunction

  // True when a 12-bit value is a multiple of five, using a reciprocal multiply.
  function automatic logic is_mult5(input logic [11:0] p);
    logic [23:0] prod;
    logic [9:0]  q;
    logic [11:0] r;
    prod = 24'(p) * 24'd3277;
    q    = prod[23:14];
    r    = p - 12'(q) * 12'd5;
    return r == 12'd0;
  endfunction

endpackage

/* sv/kst_countdown.sv */
// Run-mode countdown: prescaler, minute and hour decrement, and refresh pulse.
`timescale 1ns / 1ps

module kst_countdown (
  input  logic [11:0]          prescaler,
  input  logic [3:0]           hours,
  input  logic [5:0]           minutes,
  input  logic [11:0]          tpm,
  output kst_pkg::countdown_t  result
);

  // One running tick: decrement the prescaler or, when it expires, the time.
  always_comb begin
    result.prescaler = prescaler - 12'd1;
    result.hours     = hours;
    result.minutes   = minutes;
    result.run       = 1'b1;
    if (prescaler <= 12'd1) begin
      if (minutes == 6'd0) begin
        if (hours == 4'd0) begin
          result.run = 1'b0;
        end else begin
          result.hours   = hours - 4'd1;
          result.minutes = kst_pkg::MINUTE_MAX;
        end
      end else begin
        result.minutes = minutes - 6'd1;
      end
      result.prescaler = tpm;
    end
    result.refresh = kst_pkg::is_mult5(result.prescaler);
  end

endmodule

/* sv/kst_step.sv */
// Per-tick state update: mode sequencing followed by the work of the new mode.
`timescale 1ns / 1ps

module kst_step (
  input  kst_pkg::state_t cur,
  input  logic [7:0]      key,
  input  logic [11:0]     tpm,
  output kst_pkg::state_t nxt,
  output logic            upd
);

  kst_pkg::mode_t      mode1;
  logic [7:0]          held1;
  logic [1:0]          pos1;
  logic [11:0]         pre1;
  logic                run1;
  kst_pkg::countdown_t cd;
  logic [3:0]          digit;
  logic                key_new;

  // Next mode from the current mode and the sampled key.
  always_comb begin
    mode1 = cur.mode;
    held1 = cur.held_key;
    pos1  = cur.entry_pos;
    pre1  = cur.prescaler;
    run1  = cur.run;
    case (cur.mode)
      kst_pkg::MODE_INIT: begin
        mode1 = kst_pkg::MODE_MAIN;
      end
      kst_pkg::MODE_MAIN: begin
        held1 = key;
        if (key == kst_pkg::KEY_ONE) mode1 = kst_pkg::MODE_TPROMPT;
      end
      kst_pkg::MODE_TPROMPT: begin
        mode1 = kst_pkg::MODE_TENTRY;
        pos1  = 2'd0;
      end
      kst_pkg::MODE_TENTRY: begin
        if (cur.entry_pos == kst_pkg::ENTRY_DONE) mode1 = kst_pkg::MODE_HPROMPT;
      end
      kst_pkg::MODE_HPROMPT: begin
        mode1 = kst_pkg::MODE_HENTRY;
        pos1  = 2'd0;
      end
      kst_pkg::MODE_HENTRY: begin
        if (cur.entry_pos == kst_pkg::ENTRY_DONE) begin
          pre1  = tpm;
          mode1 = kst_pkg::MODE_RUN;
        end
      end
      kst_pkg::MODE_RUN: begin
        if (cur.minutes == 6'd0 && cur.hours == 4'd0) begin
          run1  = 1'b0;
          mode1 = kst_pkg::MODE_INIT;
        end else begin
          held1 = key;
          if (key != kst_pkg::KEY_NONE) mode1 = kst_pkg::MODE_PAUSE;
        end
      end
      default: begin
        // Pause: a fresh '1' exits, a fresh '2' resumes.
        if (key != cur.held_key) begin
          held1 = key;
          if (key == kst_pkg::KEY_ONE) mode1 = kst_pkg::MODE_INIT;
          else if (key == kst_pkg::KEY_TWO) mode1 = kst_pkg::MODE_RUN;
        end
      end
    endcase
  end

  kst_countdown u_countdown (
    .prescaler (pre1),
    .hours     (cur.hours),
    .minutes   (cur.minutes),
    .tpm       (tpm),
    .result    (cd)
  );

  assign digit   = kst_pkg::digit_value(key);
  assign key_new = (key != held1);

  // Work of the new mode.
  always_comb begin
    nxt.mode      = mode1;
    nxt.held_key  = held1;
    nxt.entry_pos = pos1;
    nxt.prescaler = pre1;
    nxt.hours     = cur.hours;
    nxt.minutes   = cur.minutes;
    nxt.set_point = cur.set_point;
    nxt.run       = run1;
    upd           = 1'b0;
    case (mode1)
      kst_pkg::MODE_INIT: begin
        nxt.hours     = 4'd0;
        nxt.minutes   = 6'd0;
        nxt.set_point = 8'd0;
        upd           = 1'b1;
      end
      kst_pkg::MODE_MAIN: begin
        nxt.held_key = kst_pkg::KEY_NONE;
        upd          = 1'b1;
      end
      kst_pkg::MODE_TPROMPT: begin
        upd = 1'b1;
      end
      kst_pkg::MODE_TENTRY: begin
        if (key_new) begin
          nxt.held_key = key;
          if (kst_pkg::is_digit(key) && pos1 != kst_pkg::ENTRY_DONE) begin
            nxt.set_point = kst_pkg::set_point_add(cur.set_point, digit, pos1);
            nxt.entry_pos = pos1 + 2'd1;
          end
          upd = 1'b1;
        end
      end
      kst_pkg::MODE_HPROMPT: begin
        upd = 1'b1;
      end
      kst_pkg::MODE_HENTRY: begin
        if (key_new) begin
          nxt.held_key = key;
          if (kst_pkg::is_digit(key)) begin
            case (pos1)
              2'd0: begin
                nxt.hours     = digit;
                nxt.entry_pos = 2'd1;
              end
              2'd1: begin
                // Minutes tens above five are ignored.
                if (digit < kst_pkg::TENS_LIMIT) begin
                  nxt.minutes   = 6'(digit) * 6'd10;
                  nxt.entry_pos = 2'd2;
                end
              end
              2'd2: begin
                nxt.minutes   = cur.minutes + 6'(digit);
                nxt.entry_pos = kst_pkg::ENTRY_DONE;
              end
              default: begin
              end
            endcase
            upd = 1'b1;
          end
        end
      end
      kst_pkg::MODE_RUN: begin
        nxt.prescaler = cd.prescaler;
        nxt.hours     = cd.hours;
        nxt.minutes   = cd.minutes;
        nxt.run       = cd.run;
        upd           = cd.refresh;
      end
      default: begin
        nxt.run = 1'b0;
        upd     = 1'b1;
      end
    endcase
  end

endmodule

/* sv/keypad_set_countdown_timer.sv */
// Top level of the keypad set-point and countdown timer with its handshake pipeline.
// A request is held in the input stage and then registered in the result register.
// Throughput: one request per cycle unless the result stalls; the state update is
// a single registered pass. A stalled result holds the pipeline; new requests are still
// taken while the input stage is empty or moving.
// Reset (rst, synchronous): init mode, all state zero, ticks_per_minute 300.
`timescale 1ns / 1ps

module keypad_set_countdown_timer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  key_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  mode,
  output logic        run_enable,
  output logic [7:0]  set_point,
  output logic [3:0]  hours_left,
  output logic [5:0]  minutes_left,
  output logic        display_update,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] ticks_per_minute
);

  kst_pkg::state_t state;
  kst_pkg::state_t state_next;
  logic [11:0]     tpm;
  logic            stage_valid;
  logic [7:0]      key_reg;
  logic            upd_next;
  logic            advance;

  assign advance   = !out_valid || out_ready;
  assign in_ready  = !stage_valid || advance;
  assign cfg_ready = 1'b1;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tpm <= kst_pkg::TPM_RESET;
    end else if (cfg_valid) begin
      tpm <= ticks_per_minute;
    end
  end

  // Input stage holds the accepted key.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      key_reg <= key_char;
    end
  end

  kst_step u_step (
    .cur (state),
    .key (key_reg),
    .tpm (tpm),
    .nxt (state_next),
    .upd (upd_next)
  );

  // Architectural state advances when the staged key moves to the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kst_pkg::STATE_RESET;
    end else if (stage_valid && advance) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_valid && advance) begin
      mode           <= 3'(state_next.mode);
      run_enable     <= state_next.run;
      set_point      <= state_next.set_point;
      hours_left     <= state_next.hours;
      minutes_left   <= state_next.minutes;
      display_update <= upd_next;
    end
  end

`ifndef NO_ASSERTIONS
  // Run enable is only high in run mode.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && run_enable |-> mode == 3'(kst_pkg::MODE_RUN))
    else $error("run_enable high outside run mode");

  // Remaining time stays within H:MM range.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (minutes_left <= kst_pkg::MINUTE_MAX) && (hours_left <= kst_pkg::HOUR_MAX))
    else $error("remaining time out of range");

  // State only changes when a staged request moves on.
  assert property (@(posedge clk) disable iff (rst)
    !(stage_valid && advance) |=> $stable(state))
    else $error("state changed without a request");
`endif

endmodule
